// ----- sv/ipc_pkg.sv -----
// ----------------------------------------------------------------------------
// Irrigation pump controller package
// Shared payload types, register indexes, LED codes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

  localparam int unsigned TICKS_PER_SECOND     = 1000;
  localparam int unsigned BLINK_HALF_PERIOD_MS = 500;
  localparam int unsigned BLINK_W              = 10;
  localparam int unsigned CFG_IDX_W            = 3;
  localparam int unsigned CFG_DATA_W           = 16;
  localparam int unsigned THRESH_W             = 7;
  localparam int unsigned CNT_W                = 32;

  localparam logic [THRESH_W-1:0] MIN_MOISTURE_RST = 7'd30;
  localparam logic [THRESH_W-1:0] MAX_MOISTURE_RST = 7'd70;
  localparam int unsigned AUTO_LIMIT_S_RST   = 60;
  localparam int unsigned MANUAL_S_RST       = 10;
  localparam int unsigned SAMPLE_INTERVAL_RST = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_MOISTURE    = 3'd0,
    CFG_MAX_MOISTURE    = 3'd1,
    CFG_AUTO_LIMIT_S    = 3'd2,
    CFG_MANUAL_S        = 3'd3,
    CFG_SAMPLE_INTERVAL = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_NORMAL   = 2'd0,
    STATUS_WATERING = 2'd1,
    STATUS_LOW      = 2'd2,
    STATUS_FAULT    = 2'd3
  } led_status_e;

  typedef enum logic [1:0] {
    COLOR_OFF    = 2'd0,
    COLOR_BLUE   = 2'd1,
    COLOR_YELLOW = 2'd2,
    COLOR_RED    = 2'd3
  } led_color_e;

  typedef struct packed {
    logic signed [7:0] moisture_sample;
    logic              auto_selected;
    logic              pump_button;
  } in_t;

  typedef struct packed {
    logic              pump_on;
    logic              mode_is_auto;
    logic [1:0]        led_status;
    logic [1:0]        led_color;
    logic signed [7:0] latched_moisture;
  } out_t;

endpackage

`default_nettype wire

// ----- sv/irrigation_pump_controller_core.sv -----
// ----------------------------------------------------------------------------
// Irrigation pump controller core
// Per-millisecond pump control with sample latching, timeouts and status LED.
// ----------------------------------------------------------------------------
// Usage: every input word on in_data_i is one millisecond tick carrying the
// moisture sample, the mode selection and the pump button. Each accepted word
// produces exactly one result word on out_data_o, in order. A word is taken
// when its valid is high and the matching stall is low.
// A word accepted into the input register moves into the result register once
// that register is free, and is presented from there until taken. Throughput
// is one word per clock while the receiver does not stall; all per-tick work
// is a single pass of compare and counter logic between the two registers, and
// the tick-limit products are formed once, on the configuration write.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word, then in_stall_o rises until the result
// is taken. Configuration writes are always accepted (cfg_ready_o is high) and
// should be issued only while no word is in flight. Unused indexes are ignored.
// Reset clears both registers, returns all controller state to auto mode with
// the pump off, and restores the default thresholds and durations.
// ----------------------------------------------------------------------------
`default_nettype none

module irrigation_pump_controller_core #(
  parameter int unsigned TicksPerSecond = ipc_pkg::TICKS_PER_SECOND
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire ipc_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output ipc_pkg::out_t                      out_data_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [ipc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [ipc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned TpsW   = $clog2(TicksPerSecond + 1);
  localparam int unsigned LimitW = ipc_pkg::CFG_DATA_W + TpsW;
  localparam int unsigned CmpW   = (LimitW > ipc_pkg::CNT_W) ? LimitW : ipc_pkg::CNT_W;
  localparam logic [ipc_pkg::BLINK_W-1:0] BlinkMax  = '1;
  localparam logic [ipc_pkg::BLINK_W-1:0] BlinkHalf =
    ipc_pkg::BLINK_W'(ipc_pkg::BLINK_HALF_PERIOD_MS);
  localparam logic [ipc_pkg::CNT_W-1:0] CntMax = '1;

  logic [ipc_pkg::THRESH_W-1:0] min_moisture_q, max_moisture_q;
  logic [LimitW-1:0]            auto_limit_q, manual_limit_q, sample_limit_q;
  logic [LimitW-1:0]            cfg_product;

  logic                 mode_auto_q, mode_auto_d;
  logic                 pump_q, pump_d;
  logic [ipc_pkg::CNT_W-1:0] wat_q, wat_d;
  logic [7:0]           held_q, held_d;
  logic [ipc_pkg::CNT_W-1:0] samp_q, samp_d;
  logic                 sampled_q, sampled_d;
  logic [1:0]           prev_status_q, prev_status_d;
  logic                 blink_phase_q, blink_phase_d;
  logic [ipc_pkg::BLINK_W-1:0] blink_q, blink_d;
  logic [1:0]           color_q, color_d;

  logic          s1_valid_q;
  ipc_pkg::in_t  s1_data_q;
  logic          out_valid_q;
  ipc_pkg::out_t out_data_q, out_data_d;
  logic          out_free, s1_advance, in_accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_product = LimitW'(cfg_data_i) * LimitW'(TicksPerSecond);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_moisture_q <= ipc_pkg::MIN_MOISTURE_RST;
      max_moisture_q <= ipc_pkg::MAX_MOISTURE_RST;
      auto_limit_q   <= LimitW'(ipc_pkg::AUTO_LIMIT_S_RST * TicksPerSecond);
      manual_limit_q <= LimitW'(ipc_pkg::MANUAL_S_RST * TicksPerSecond);
      sample_limit_q <= LimitW'(ipc_pkg::SAMPLE_INTERVAL_RST * TicksPerSecond);
    end else if (cfg_valid_i) begin
      case (ipc_pkg::cfg_idx_e'(cfg_index_i))
        ipc_pkg::CFG_MIN_MOISTURE:    min_moisture_q <= cfg_data_i[ipc_pkg::THRESH_W-1:0];
        ipc_pkg::CFG_MAX_MOISTURE:    max_moisture_q <= cfg_data_i[ipc_pkg::THRESH_W-1:0];
        ipc_pkg::CFG_AUTO_LIMIT_S:    auto_limit_q   <= cfg_product;
        ipc_pkg::CFG_MANUAL_S:        manual_limit_q <= cfg_product;
        ipc_pkg::CFG_SAMPLE_INTERVAL: sample_limit_q <= cfg_product;
        default: ;
      endcase
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_advance  = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    logic [ipc_pkg::CNT_W-1:0] wat_inc;
    logic [ipc_pkg::CNT_W-1:0] samp_inc;
    logic                      latch;
    logic                      neg;
    logic [6:0]                mag;
    logic                      le_min, lt_min, ge_max;
    logic [1:0]                status;

    wat_inc  = (wat_q == CntMax) ? wat_q : wat_q + 1'b1;
    blink_d  = (blink_q < BlinkMax) ? blink_q + 1'b1 : blink_q;
    samp_inc = sampled_q ? ((samp_q == CntMax) ? samp_q : samp_q + 1'b1) : samp_q;

    latch     = !sampled_q || (CmpW'(samp_inc) >= CmpW'(sample_limit_q));
    held_d    = latch ? s1_data_q.moisture_sample : held_q;
    samp_d    = latch ? '0 : samp_inc;
    sampled_d = 1'b1;

    neg    = held_d[7];
    mag    = held_d[6:0];
    le_min = !neg && (mag <= min_moisture_q);
    lt_min = !neg && (mag < min_moisture_q);
    ge_max = !neg && (mag >= max_moisture_q);

    mode_auto_d = mode_auto_q;
    pump_d      = pump_q;
    wat_d       = wat_inc;

    if (s1_data_q.auto_selected) begin
      mode_auto_d = 1'b1;
      if (neg) begin
        pump_d = 1'b0;
      end else if (le_min && !pump_q) begin
        pump_d = 1'b1;
        wat_d  = '0;
      end else if (ge_max || (CmpW'(wat_inc) > CmpW'(auto_limit_q))) begin
        pump_d = 1'b0;
      end
    end else begin
      if (mode_auto_q) begin
        pump_d      = 1'b0;
        mode_auto_d = 1'b0;
      end else if (s1_data_q.pump_button && !pump_q) begin
        pump_d = 1'b1;
        wat_d  = '0;
      end else if (pump_q && (CmpW'(wat_inc) > CmpW'(manual_limit_q))) begin
        pump_d = 1'b0;
      end
    end

    if (pump_d) begin
      status = ipc_pkg::STATUS_WATERING;
    end else if (neg) begin
      status = ipc_pkg::STATUS_FAULT;
    end else if (lt_min) begin
      status = ipc_pkg::STATUS_LOW;
    end else begin
      status = ipc_pkg::STATUS_NORMAL;
    end

    color_d       = color_q;
    blink_phase_d = blink_phase_q;
    case (ipc_pkg::led_status_e'(status))
      ipc_pkg::STATUS_NORMAL:   color_d = ipc_pkg::COLOR_BLUE;
      ipc_pkg::STATUS_WATERING: color_d = ipc_pkg::COLOR_YELLOW;
      ipc_pkg::STATUS_FAULT:    color_d = ipc_pkg::COLOR_RED;
      default: begin
        if (prev_status_q != ipc_pkg::STATUS_LOW) begin
          color_d       = ipc_pkg::COLOR_RED;
          blink_phase_d = 1'b1;
          blink_d       = '0;
        end
        if (blink_d >= BlinkHalf) begin
          color_d       = blink_phase_d ? ipc_pkg::COLOR_OFF : ipc_pkg::COLOR_RED;
          blink_phase_d = !blink_phase_d;
          blink_d       = '0;
        end
      end
    endcase
    prev_status_d = status;

    out_data_d.pump_on          = pump_d;
    out_data_d.mode_is_auto     = mode_auto_d;
    out_data_d.led_status       = status;
    out_data_d.led_color        = color_d;
    out_data_d.latched_moisture = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      mode_auto_q   <= 1'b1;
      pump_q        <= 1'b0;
      wat_q         <= '0;
      held_q        <= '0;
      samp_q        <= '0;
      sampled_q     <= 1'b0;
      prev_status_q <= ipc_pkg::STATUS_NORMAL;
      blink_phase_q <= 1'b0;
      blink_q       <= '0;
      color_q       <= ipc_pkg::COLOR_OFF;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_advance) begin
        mode_auto_q   <= mode_auto_d;
        pump_q        <= pump_d;
        wat_q         <= wat_d;
        held_q        <= held_d;
        samp_q        <= samp_d;
        sampled_q     <= sampled_d;
        prev_status_q <= prev_status_d;
        blink_phase_q <= blink_phase_d;
        blink_q       <= blink_d;
        color_q       <= color_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
    if (s1_advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ipc_checker.sv -----
// ----------------------------------------------------------------------------
// Irrigation pump controller checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input wire ipc_pkg::out_t  out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("Stalled result word changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pump_on ==
                     (out_data_o.led_status == ipc_pkg::STATUS_WATERING)))
    else $error("Pump drive and watering status disagree.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.led_status == ipc_pkg::STATUS_FAULT) |->
      (out_data_o.led_color == ipc_pkg::COLOR_RED && out_data_o.latched_moisture < 0))
    else $error("Sensor error not shown as solid red with a negative sample.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.led_status == ipc_pkg::STATUS_WATERING) |->
      (out_data_o.led_color == ipc_pkg::COLOR_YELLOW))
    else $error("Watering not shown as yellow.");

endmodule

bind irrigation_pump_controller_core ipc_checker u_ipc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
